FILE: rtl/psfp_pkg.sv
// shared types and constants for the particle sensor frame parser
`default_nettype none

package psfp_pkg;

  // frame layout
  localparam int unsigned FRAME_BYTES = 32;
  localparam int unsigned POS_W       = $clog2(FRAME_BYTES);
  localparam logic [POS_W-1:0] POS_HDR_END  = POS_W'(3);
  localparam logic [POS_W-1:0] POS_VAL_FIRST = POS_W'(10);
  localparam logic [POS_W-1:0] POS_VAL_LAST  = POS_W'(15);
  localparam logic [POS_W-1:0] POS_SUM_HI    = POS_W'(30);
  localparam logic [POS_W-1:0] POS_LAST      = POS_W'(FRAME_BYTES - 1);

  // expected header bytes
  localparam logic [7:0] HDR_B0 = 8'h42;
  localparam logic [7:0] HDR_B1 = 8'h4D;
  localparam logic [7:0] HDR_B2 = 8'h00;
  localparam logic [7:0] HDR_B3 = 8'h1C;

  // configuration reset value
  localparam logic [15:0] CEILING_RESET = 16'd999;

  // default depth of the event queue between front and back
  localparam int unsigned PSFP_QUEUE_DEPTH = 4;

  // result status codes
  localparam logic [1:0] ST_NORMAL  = 2'd0;
  localparam logic [1:0] ST_CLAMPED = 2'd1;
  localparam logic [1:0] ST_ERROR   = 2'd2;

  // input transaction
  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } psfp_in_t;

  // result transaction
  typedef struct packed {
    logic [15:0] pm1_value;
    logic [15:0] pm25_value;
    logic [15:0] pm10_value;
    logic [1:0]  status;
    logic        values_updated;
  } psfp_out_t;

  // classified frame event from front to back
  typedef struct packed {
    logic        bad;
    logic [47:0] values;
  } psfp_evt_t;

endpackage

`default_nettype wire

FILE: rtl/psfp_front.sv
// byte classifier: frame position, header check, checksum and value capture
`default_nettype none

module psfp_front
  import psfp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire psfp_in_t  in_data,
  input  wire logic      q_full,
  output logic           evt_push,
  output psfp_evt_t      evt_data
);

  logic [POS_W-1:0] pos_r, pos_nxt, pos_eff;
  logic             hunt_r, hunt_nxt, hunt_eff;
  logic [15:0]      sum_r, sum_nxt, sum_eff;
  logic [47:0]      pend_r, pend_nxt, pend_eff;
  logic [7:0]       hold_r, hold_nxt;
  logic             acc;
  logic             bad;
  logic [7:0]       b;

  // only stall when the event queue cannot take a result
  assign in_stall = q_full;
  assign acc      = in_valid && !q_full;
  assign b        = in_data.data_byte;

  // frame start clears the frame state before this byte is handled
  always_comb begin
    pos_eff  = in_data.first_byte ? '0 : pos_r;
    hunt_eff = in_data.first_byte ? 1'b0 : hunt_r;
    sum_eff  = in_data.first_byte ? '0 : sum_r;
    pend_eff = in_data.first_byte ? '0 : pend_r;
  end

  // header byte check
  always_comb begin
    bad = 1'b0;
    if (pos_eff <= POS_HDR_END) begin
      case (pos_eff[1:0])
        2'd0:    bad = (b != HDR_B0);
        2'd1:    bad = (b != HDR_B1);
        2'd2:    bad = (b != HDR_B2);
        2'd3:    bad = (b != HDR_B3);
        default: bad = 1'b0;
      endcase
    end
  end

  // next frame state and event generation
  always_comb begin
    pos_nxt  = pos_r;
    hunt_nxt = hunt_r;
    sum_nxt  = sum_r;
    pend_nxt = pend_r;
    hold_nxt = hold_r;
    evt_push = 1'b0;
    evt_data = '0;
    if (acc) begin
      pos_nxt  = pos_eff;
      hunt_nxt = hunt_eff;
      sum_nxt  = sum_eff;
      pend_nxt = pend_eff;
      if (!hunt_eff) begin
        if (bad) begin
          hunt_nxt     = 1'b1;
          pos_nxt      = '0;
          evt_push     = 1'b1;
          evt_data.bad = 1'b1;
        end else begin
          if (pos_eff < POS_SUM_HI) begin
            sum_nxt = sum_eff + {8'd0, b};
          end
          if (pos_eff inside {[POS_VAL_FIRST:POS_VAL_LAST]}) begin
            pend_nxt = {pend_eff[39:0], b};
          end
          if (pos_eff == POS_SUM_HI) begin
            hold_nxt = b;
          end
          if (pos_eff != POS_LAST) begin
            pos_nxt = pos_eff + POS_W'(1);
          end else begin
            // last byte: compare checksum and hand the frame to the back
            hunt_nxt        = 1'b1;
            pos_nxt         = '0;
            evt_push        = 1'b1;
            evt_data.values = pend_eff;
            evt_data.bad    = !((hold_r == sum_eff[15:8]) && (b == sum_eff[7:0]));
          end
        end
      end
    end
  end

  // frame state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      hunt_r <= 1'b1;
      sum_r  <= '0;
      pend_r <= '0;
      hold_r <= '0;
    end else begin
      pos_r  <= pos_nxt;
      hunt_r <= hunt_nxt;
      sum_r  <= sum_nxt;
      pend_r <= pend_nxt;
      hold_r <= hold_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/psfp_queue.sv
// short event queue between the byte classifier and the result stage
`default_nettype none

module psfp_queue
  import psfp_pkg::*;
#(
  parameter int unsigned DEPTH = PSFP_QUEUE_DEPTH
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire psfp_evt_t push_data,
  output logic           full,
  input  wire logic      pop,
  output logic           not_empty,
  output psfp_evt_t      head
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  psfp_evt_t        mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full      = (cnt_r == CNT_FULL);
  assign not_empty = (cnt_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head      = mem[rd_ptr_r];

  // occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  // pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/psfp_back.sv
// result stage: clamping, stored values, ceiling register and output register
`default_nettype none

module psfp_back
  import psfp_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   cfg_valid,
  output logic        cfg_ready,
  input  wire logic [15:0] cfg_data,
  input  wire logic   q_not_empty,
  input  wire psfp_evt_t q_head,
  output logic        q_pop,
  output logic        out_valid,
  input  wire logic   out_stall,
  output psfp_out_t   out_data
);

  logic [15:0] ceil_r;
  logic [15:0] pm1_r, pm25_r, pm10_r;
  logic [15:0] pm1_c, pm25_c, pm10_c;
  logic        clp1, clp25, clp10;
  logic        out_valid_r;
  psfp_out_t   out_data_r, out_data_nxt;

  // clamp to ceiling, then raise zero to one
  function automatic logic [16:0] clamp_val(input logic [15:0] v, input logic [15:0] ceil);
    logic [15:0] r;
    logic        c;
    begin
      r = v;
      c = 1'b0;
      if (v > ceil) begin
        r = ceil;
        c = 1'b1;
      end
      if (r == '0) begin
        r = 16'd1;
      end
      return {c, r};
    end
  endfunction

  assign cfg_ready = 1'b1;
  assign q_pop     = q_not_empty && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign {clp1,  pm1_c}  = clamp_val(q_head.values[47:32], ceil_r);
  assign {clp25, pm25_c} = clamp_val(q_head.values[31:16], ceil_r);
  assign {clp10, pm10_c} = clamp_val(q_head.values[15:0],  ceil_r);

  // build the result for the event at the queue head
  always_comb begin
    out_data_nxt.pm1_value      = pm1_r;
    out_data_nxt.pm25_value     = pm25_r;
    out_data_nxt.pm10_value     = pm10_r;
    out_data_nxt.status         = ST_ERROR;
    out_data_nxt.values_updated = 1'b0;
    if (!q_head.bad) begin
      out_data_nxt.pm1_value      = pm1_c;
      out_data_nxt.pm25_value     = pm25_c;
      out_data_nxt.pm10_value     = pm10_c;
      out_data_nxt.status         = (clp1 || clp25 || clp10) ? ST_CLAMPED : ST_NORMAL;
      out_data_nxt.values_updated = 1'b1;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_data_r <= out_data_nxt;
    end
  end

  // ceiling, stored values and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ceil_r      <= CEILING_RESET;
      pm1_r       <= 16'd1;
      pm25_r      <= 16'd1;
      pm10_r      <= 16'd1;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        ceil_r <= cfg_data;
      end
      if (q_pop) begin
        out_valid_r <= 1'b1;
        if (!q_head.bad) begin
          pm1_r  <= pm1_c;
          pm25_r <= pm25_c;
          pm10_r <= pm10_c;
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/particle_sensor_frame_parser_core.sv
// top level of the particle sensor frame parser
//
// Input channel in_valid/in_stall/in_data carries one received byte per
// transaction; in_data.first_byte marks the first byte after a line idle gap.
// Output channel out_valid/out_stall/out_data carries one result after the
// last byte of a frame (values and clamp status, or checksum error) or at the
// first wrong header byte (error status, stored values unchanged).
// Configuration channel cfg_valid/cfg_ready/cfg_data writes the 16-bit value
// ceiling; cfg_ready is always high. Write it only while the block is idle.
// Throughput: one byte per cycle while in_stall is low. The classifier pushes
// the event of a frame-ending byte into the queue when the byte is accepted; the
// result stage pops it, in order, into the output register when that is free.
// When the receiver stalls, the result holds in the output register and
// further frame events collect in the event queue (QUEUE_DEPTH entries);
// in_stall rises only once that queue is full.
// Reset (rst_n low, synchronous) empties the queue, sets the ceiling to 999,
// the stored values to 1 and makes the parser wait for a frame start.
`default_nettype none

module particle_sensor_frame_parser_core
  import psfp_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = PSFP_QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire psfp_in_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output psfp_out_t        out_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [15:0] cfg_data
);

  logic      evt_push;
  psfp_evt_t evt_data;
  logic      q_full, q_not_empty, q_pop;
  psfp_evt_t q_head;

  // byte classifier
  psfp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .evt_push (evt_push),
    .evt_data (evt_data)
  );

  // event queue
  psfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (evt_push),
    .push_data (evt_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  // result stage
  psfp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

`default_nettype wire

FILE: rtl/psfp_checker.sv
// port-level checks for the particle sensor frame parser, bound to the top level
`default_nettype none

module psfp_checker
  import psfp_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire psfp_out_t out_data
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // new values come only with a normal or clamped status
  a_upd_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.values_updated |->
      (out_data.status == ST_NORMAL || out_data.status == ST_CLAMPED))
    else $error("updated values with error status");

  // a result without updated values is always an error
  a_err_kept: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.values_updated |-> out_data.status == ST_ERROR)
    else $error("result without update must be an error");

  // reported concentrations are never zero
  a_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.pm1_value != '0 && out_data.pm25_value != '0 &&
                  out_data.pm10_value != '0)
    else $error("zero concentration reported");

endmodule

bind particle_sensor_frame_parser_core psfp_checker u_psfp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

FILE: test/tb_top.sv
// testbench for the particle sensor frame parser: byte stream stimulus, result checking
`default_nettype none

module tb_top
  import psfp_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES    = 400000;
  localparam int SETTLE_CYCLES   = 4;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int RANDOM_BYTES    = 224;

  // dut ports
  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  psfp_in_t  in_data;
  logic      out_valid;
  logic      out_stall;
  psfp_out_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [15:0] cfg_data;

  // parser state mirrored by the testbench
  logic [15:0] ceiling_q;
  logic [5:0]  frame_pos;
  bit          hunt;
  logic [15:0] sum_acc;
  logic [7:0]  sum_hi;
  logic [15:0] pm1_kept;
  logic [15:0] pm25_kept;
  logic [15:0] pm10_kept;
  logic [47:0] conc_pend;

  // readings still owed by the block, oldest first
  psfp_out_t expected_readings[$];

  // frame under construction
  logic [7:0] frame_buf [32];

  // traffic shaping
  int send_idle_pct;
  int recv_idle_pct;
  int hold_request;
  int hold_left;

  // bookkeeping
  int cycle_count;
  int fail_count;
  int bytes_sent;
  int input_stalls;
  int readings_seen;
  int updates_seen;
  int clamps_seen;
  int errors_seen;

  particle_sensor_frame_parser_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
        $display("timeout after %0d cycles, %0d readings outstanding", cycle_count,
                 expected_readings.size());
        $display("FAIL particle_sensor_frame_parser_core");
        $finish;
      end
    end
  end

  // receiver: random stalls plus an occasional long hold-off
  initial begin
    hold_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
      end
    end
  end

  // one line per mismatch
  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    fail_count++;
    $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
  endtask

  // result checker: sampled mid-cycle, accepted at the next rising edge
  initial begin
    psfp_out_t want;
    forever begin
      @(negedge clk);
      if (rst_n && out_valid && !out_stall) begin
        readings_seen++;
        if (expected_readings.size() == 0) begin
          report_mismatch("result with none pending, status", 16'(out_data.status), 16'd0);
        end else begin
          want = expected_readings.pop_front();
          if (out_data.pm1_value !== want.pm1_value)
            report_mismatch("pm1_value", out_data.pm1_value, want.pm1_value);
          if (out_data.pm25_value !== want.pm25_value)
            report_mismatch("pm25_value", out_data.pm25_value, want.pm25_value);
          if (out_data.pm10_value !== want.pm10_value)
            report_mismatch("pm10_value", out_data.pm10_value, want.pm10_value);
          if (out_data.status !== want.status)
            report_mismatch("status", 16'(out_data.status), 16'(want.status));
          if (out_data.values_updated !== want.values_updated)
            report_mismatch("values_updated", 16'(out_data.values_updated),
                            16'(want.values_updated));
          if (want.values_updated) updates_seen++;
          if (want.status == ST_CLAMPED) clamps_seen++;
          if (want.status == ST_ERROR) errors_seen++;
        end
      end
    end
  end

  // clamp one concentration to the ceiling, then raise zero to one
  function automatic logic [15:0] clamp_conc(input logic [15:0] v, inout bit hit);
    logic [15:0] r;
    r = v;
    if (r > ceiling_q) begin
      r = ceiling_q;
      hit = 1'b1;
    end
    if (r == 16'd0) r = 16'd1;
    return r;
  endfunction

  // reading for the kept values with a given status
  function automatic psfp_out_t kept_reading(input logic [1:0] st, input logic upd);
    psfp_out_t r;
    r.pm1_value      = pm1_kept;
    r.pm25_value     = pm25_kept;
    r.pm10_value     = pm10_kept;
    r.status         = st;
    r.values_updated = upd;
    return r;
  endfunction

  // advance the parser by one byte; returns 1 when a reading is due
  function automatic bit parse_byte(input logic [7:0] b, input logic f, output psfp_out_t res);
    bit bad;
    bit hit;
    bad = 1'b0;
    hit = 1'b0;
    res = '0;
    if (f) begin
      hunt      = 1'b0;
      frame_pos = '0;
      sum_acc   = '0;
      conc_pend = '0;
    end
    if (hunt) return 1'b0;
    case (frame_pos)
      6'd0: bad = (b != HDR_B0);
      6'd1: bad = (b != HDR_B1);
      6'd2: bad = (b != HDR_B2);
      6'd3: bad = (b != HDR_B3);
      default: bad = 1'b0;
    endcase
    if (bad) begin
      hunt      = 1'b1;
      frame_pos = '0;
      res = kept_reading(ST_ERROR, 1'b0);
      return 1'b1;
    end
    if (frame_pos < 6'(POS_SUM_HI)) sum_acc = sum_acc + 16'(b);
    if (frame_pos >= 6'(POS_VAL_FIRST) && frame_pos <= 6'(POS_VAL_LAST))
      conc_pend = {conc_pend[39:0], b};
    if (frame_pos == 6'(POS_SUM_HI)) sum_hi = b;
    if (frame_pos < 6'(POS_LAST)) begin
      frame_pos = frame_pos + 6'd1;
      return 1'b0;
    end
    // last byte of the frame
    hunt      = 1'b1;
    frame_pos = '0;
    if (sum_hi == sum_acc[15:8] && b == sum_acc[7:0]) begin
      pm1_kept  = clamp_conc(conc_pend[47:32], hit);
      pm25_kept = clamp_conc(conc_pend[31:16], hit);
      pm10_kept = clamp_conc(conc_pend[15:0], hit);
      res = kept_reading(hit ? ST_CLAMPED : ST_NORMAL, 1'b1);
    end else begin
      res = kept_reading(ST_ERROR, 1'b0);
    end
    return 1'b1;
  endfunction

  // offer one byte, hold it until accepted, then predict
  task automatic send_byte(input logic [7:0] b, input logic f);
    psfp_out_t res;
    bit taken;
    taken = 1'b0;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{data_byte: b, first_byte: f};
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      if (!taken) input_stalls++;
      @(posedge clk);
    end
    bytes_sent++;
    if (parse_byte(b, f, res)) expected_readings.push_back(res);
  endtask

  // stop sending and wait for every owed reading plus the pipeline
  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ceiling write, only while idle
  task automatic write_ceiling(input logic [15:0] v);
    bit taken;
    taken = 1'b0;
    wait_for_results();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    while (!taken) begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end
    ceiling_q = v;
    cfg_valid <= 1'b0;
  endtask

  // well-formed frame with the given concentrations and random filler
  function automatic void build_frame(input logic [15:0] v1, input logic [15:0] v2,
                                      input logic [15:0] v3);
    logic [15:0] s;
    s = '0;
    for (int i = 4; i < 30; i++) frame_buf[i] = 8'($urandom);
    frame_buf[0]  = HDR_B0;
    frame_buf[1]  = HDR_B1;
    frame_buf[2]  = HDR_B2;
    frame_buf[3]  = HDR_B3;
    frame_buf[10] = v1[15:8];
    frame_buf[11] = v1[7:0];
    frame_buf[12] = v2[15:8];
    frame_buf[13] = v2[7:0];
    frame_buf[14] = v3[15:8];
    frame_buf[15] = v3[7:0];
    for (int i = 0; i < 30; i++) s = s + 16'(frame_buf[i]);
    frame_buf[30] = s[15:8];
    frame_buf[31] = s[7:0];
  endfunction

  // send the first n bytes of the frame buffer, flagging the first
  task automatic send_frame(input int n);
    for (int i = 0; i < n; i++) send_byte(frame_buf[i], i == 0);
  endtask

  // concentration biased toward zero, the ceiling and full scale
  function automatic logic [15:0] rand_conc();
    int unsigned c;
    c = ceiling_q;
    case ($urandom_range(5))
      0: return 16'd0;
      1: return 16'($urandom_range(c));
      2: return 16'(c + $urandom_range(2) - 1);
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // bytes flagged 0 while hunting are dropped; the first flagged byte is checked
  task automatic test_hunting_after_reset();
    for (int i = 0; i < 3; i++) send_byte(8'($urandom), 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(HDR_B0, 1'b0);
    wait_for_results();
  endtask

  // good frames at the reset ceiling: in range, zero, at and over the ceiling
  task automatic test_good_frames();
    build_frame(16'd1, 16'd2, 16'd3);
    send_frame(32);
    build_frame(16'd0, 16'd0, 16'd0);
    send_frame(32);
    build_frame(16'd999, 16'd1000, 16'hFFFF);
    send_frame(32);
    // bytes past the end of a frame are ignored
    for (int i = 0; i < 4; i++) send_byte(8'($urandom), 1'b0);
    wait_for_results();
  endtask

  // a wrong byte at each header position
  task automatic test_header_errors();
    for (int k = 0; k < 4; k++) begin
      build_frame(16'd5, 16'd6, 16'd7);
      frame_buf[k] = frame_buf[k] ^ 8'($urandom_range(1, 255));
      send_frame(k + 3);
    end
    wait_for_results();
  endtask

  // checksum high byte, low byte and a payload byte corrupted
  task automatic test_checksum_errors();
    build_frame(16'd11, 16'd12, 16'd13);
    frame_buf[30] = frame_buf[30] ^ 8'h80;
    send_frame(32);
    build_frame(16'd21, 16'd22, 16'd23);
    frame_buf[31] = frame_buf[31] ^ 8'h01;
    send_frame(32);
    build_frame(16'd31, 16'd32, 16'd33);
    frame_buf[12] = frame_buf[12] ^ 8'h40;
    send_frame(32);
    wait_for_results();
  endtask

  // frame start inside a frame drops the partial frame silently
  task automatic test_frame_restart();
    build_frame(16'd100, 16'd200, 16'd300);
    send_frame(20);
    build_frame(16'd400, 16'd500, 16'd600);
    send_frame(32);
    wait_for_results();
  endtask

  // ceiling of one, full scale and zero
  task automatic test_ceiling_extremes();
    write_ceiling(16'd1);
    build_frame(16'd0, 16'd1, 16'd2);
    send_frame(32);
    write_ceiling(16'hFFFF);
    build_frame(16'hFFFF, 16'd0, 16'd1234);
    send_frame(32);
    write_ceiling(16'd0);
    build_frame(16'd0, 16'd0, 16'd0);
    send_frame(32);
    build_frame(16'd0, 16'd7, 16'd0);
    send_frame(32);
    write_ceiling(CEILING_RESET);
  endtask

  // receiver holds off while a stream of error bytes fills the block
  task automatic test_input_backpressure();
    int stalls_before;
    stalls_before = input_stalls;
    send_idle_pct = 0;
    hold_request  = HOLD_OFF_CYCLES;
    @(posedge clk);
    for (int i = 0; i < 40; i++) send_byte(8'($urandom_range(0, 8'h41)), 1'b1);
    wait_for_results();
    $display("long receiver hold-off: input stalled for %0d cycles",
             input_stalls - stalls_before);
  endtask

  // one random frame scenario, mostly well formed
  task automatic send_random_frame();
    int kind;
    int pos;
    kind = $urandom_range(99);
    build_frame(rand_conc(), rand_conc(), rand_conc());
    if (kind < 65) begin
      send_frame(32);
      if ($urandom_range(9) == 0)
        for (int i = 0; i < $urandom_range(1, 4); i++) send_byte(8'($urandom), 1'b0);
    end else if (kind < 75) begin
      pos = $urandom_range(4, 31);
      frame_buf[pos] = frame_buf[pos] ^ 8'($urandom_range(1, 255));
      send_frame(32);
    end else if (kind < 83) begin
      pos = $urandom_range(0, 3);
      frame_buf[pos] = frame_buf[pos] ^ 8'($urandom_range(1, 255));
      send_frame($urandom_range(pos + 1, 32));
    end else if (kind < 91) begin
      send_frame($urandom_range(1, 31));
    end else begin
      for (int i = 0; i < $urandom_range(1, 8); i++)
        send_byte(8'($urandom), $urandom_range(3) == 0);
    end
  endtask

  // random traffic phase with its own idle mix and ceiling
  task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                     input logic [15:0] ceil, input int budget);
    int first;
    write_ceiling(ceil);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    first = bytes_sent;
    while (bytes_sent - first < budget) send_random_frame();
    wait_for_results();
  endtask

  // main sequence
  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    send_idle_pct = 17;
    recv_idle_pct = 77;
    hold_request  = 0;
    fail_count    = 0;
    bytes_sent    = 0;
    input_stalls  = 0;
    readings_seen = 0;
    updates_seen  = 0;
    clamps_seen   = 0;
    errors_seen   = 0;

    // reset state of the mirror
    ceiling_q = CEILING_RESET;
    frame_pos = '0;
    hunt      = 1'b1;
    sum_acc   = '0;
    sum_hi    = '0;
    pm1_kept  = 16'd1;
    pm25_kept = 16'd1;
    pm10_kept = 16'd1;
    conc_pend = '0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_hunting_after_reset();
    test_good_frames();
    test_header_errors();
    test_checksum_errors();
    test_frame_restart();
    test_ceiling_extremes();
    test_input_backpressure();
    test_random_traffic(17, 77, 16'($urandom_range(50, 5000)), RANDOM_BYTES);
    test_random_traffic(77, 17, 16'hFFFF, RANDOM_BYTES);
    test_random_traffic(0, 0, 16'($urandom_range(1, 65535)), RANDOM_BYTES);

    wait_for_results();
    while (expected_readings.size() != 0) begin
      report_mismatch("reading never delivered, status",
                      16'd0, 16'(expected_readings[0].status));
      void'(expected_readings.pop_front());
    end

    $display("sent %0d bytes in %0d cycles; %0d readings checked:", bytes_sent,
             cycle_count, readings_seen);
    $display("%0d updates, %0d clamped, %0d errors; ceilings 0, 1, 999, full scale, random",
             updates_seen, clamps_seen, errors_seen);
    if (fail_count == 0) begin
      $display("PASS particle_sensor_frame_parser_core");
    end else begin
      $display("FAIL particle_sensor_frame_parser_core");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: particle_sensor_frame_parser_core.f
rtl/psfp_pkg.sv
rtl/psfp_front.sv
rtl/psfp_queue.sv
rtl/psfp_back.sv
rtl/particle_sensor_frame_parser_core.sv
rtl/psfp_checker.sv
test/tb_top.sv
